[hw/rtl/pfc_pkg.sv]
// Shared types, format codes and BT.601 coefficients for the pixel format converter.
`timescale 1ns / 1ps

package pfc_pkg;

    // source_format codes
    localparam logic [2:0] FMT_RGB8  = 3'd0;
    localparam logic [2:0] FMT_BGR8  = 3'd1;
    localparam logic [2:0] FMT_RGBA8 = 3'd2;
    localparam logic [2:0] FMT_BGRA8 = 3'd3;
    localparam logic [2:0] FMT_Y8    = 3'd4;
    localparam logic [2:0] FMT_Y16   = 3'd5;
    localparam logic [2:0] FMT_YUYV  = 3'd6;
    localparam logic [2:0] FMT_UYVY  = 3'd7;

    // configuration register index (word address)
    localparam logic REG_SOURCE_FORMAT = 1'b0;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // BT.601 integer coefficients, 8-bit fraction
    localparam int PROD_W = 19;
    localparam int SUM_W  = 20;
    localparam logic signed [PROD_W-1:0] K_Y  = 19'sd298;
    localparam logic signed [PROD_W-1:0] K_RV = 19'sd409;
    localparam logic signed [PROD_W-1:0] K_GU = 19'sd100;
    localparam logic signed [PROD_W-1:0] K_GV = 19'sd208;
    localparam logic signed [PROD_W-1:0] K_BU = 19'sd516;
    localparam logic signed [SUM_W-1:0]  K_ROUND = 20'sd128;
    localparam logic signed [9:0]        Y_OFFSET = 10'sd16;
    localparam logic signed [8:0]        C_OFFSET = 9'sd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] alpha_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic [7:0] alpha_second;
        logic [1:0] pixel_count;
    } t_result;

    // floor(sum / 256) limited to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-9:0] q;
        q = sum[SUM_W-1:8];
        if (q[SUM_W-9]) begin
            clamp_byte = 8'd0;
        end else if (q[SUM_W-10:8] != '0) begin
            clamp_byte = 8'hFF;
        end else begin
            clamp_byte = q[7:0];
        end
    endfunction

endpackage

[hw/rtl/pfc_yuv_lane.sv]
// One YUV to RGB lane: registered coefficient products, then sum, shift and clamp.
`timescale 1ns / 1ps

module pfc_yuv_lane (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [7:0]      i_luma,
    input  logic [7:0]      i_cb,
    input  logic [7:0]      i_cr,
    output pfc_pkg::t_pixel o_pixel
);
    import pfc_pkg::*;

    logic signed [9:0]        w_c;
    logic signed [8:0]        w_d;
    logic signed [8:0]        w_e;
    logic signed [PROD_W-1:0] w_c_ext;
    logic signed [PROD_W-1:0] w_d_ext;
    logic signed [PROD_W-1:0] w_e_ext;

    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] r_prv;
    logic signed [PROD_W-1:0] r_pgu;
    logic signed [PROD_W-1:0] r_pgv;
    logic signed [PROD_W-1:0] r_pbu;

    logic signed [SUM_W-1:0]  w_sum_r;
    logic signed [SUM_W-1:0]  w_sum_g;
    logic signed [SUM_W-1:0]  w_sum_b;

    assign w_c = $signed({2'b00, i_luma}) - Y_OFFSET;
    assign w_d = $signed({1'b0, i_cb}) - C_OFFSET;
    assign w_e = $signed({1'b0, i_cr}) - C_OFFSET;

    assign w_c_ext = PROD_W'(w_c);
    assign w_d_ext = PROD_W'(w_d);
    assign w_e_ext = PROD_W'(w_e);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_py  <= w_c_ext * K_Y;
            r_prv <= w_e_ext * K_RV;
            r_pgu <= w_d_ext * K_GU;
            r_pgv <= w_e_ext * K_GV;
            r_pbu <= w_d_ext * K_BU;
        end
    end

    assign w_sum_r = SUM_W'(r_py) + SUM_W'(r_prv) + K_ROUND;
    assign w_sum_g = SUM_W'(r_py) - SUM_W'(r_pgu) - SUM_W'(r_pgv) + K_ROUND;
    assign w_sum_b = SUM_W'(r_py) + SUM_W'(r_pbu) + K_ROUND;

    assign o_pixel.red   = clamp_byte(w_sum_r);
    assign o_pixel.green = clamp_byte(w_sum_g);
    assign o_pixel.blue  = clamp_byte(w_sum_b);

endmodule

[hw/rtl/pfc_merge.sv]
// Merge stage: picks reordered bytes or the two YUV lane pixels by source format.
`timescale 1ns / 1ps

module pfc_merge (
    input  logic [2:0]       i_format,
    input  logic [7:0]       i_byte_zero,
    input  logic [7:0]       i_byte_one,
    input  logic [7:0]       i_byte_two,
    input  logic [7:0]       i_byte_three,
    input  pfc_pkg::t_pixel  i_lane_first,
    input  pfc_pkg::t_pixel  i_lane_second,
    output pfc_pkg::t_result o_result
);
    import pfc_pkg::*;

    always_comb begin
        o_result              = '0;
        o_result.alpha_first  = ALPHA_OPAQUE;
        o_result.pixel_count  = COUNT_ONE;
        unique case (i_format) inside
            FMT_RGB8, FMT_RGBA8: begin
                o_result.red_first   = i_byte_zero;
                o_result.green_first = i_byte_one;
                o_result.blue_first  = i_byte_two;
                if (i_format == FMT_RGBA8) begin
                    o_result.alpha_first = i_byte_three;
                end
            end
            FMT_BGR8, FMT_BGRA8: begin
                o_result.red_first   = i_byte_two;
                o_result.green_first = i_byte_one;
                o_result.blue_first  = i_byte_zero;
                if (i_format == FMT_BGRA8) begin
                    o_result.alpha_first = i_byte_three;
                end
            end
            FMT_Y8: begin
                o_result.red_first   = i_byte_zero;
                o_result.green_first = i_byte_zero;
                o_result.blue_first  = i_byte_zero;
            end
            FMT_Y16: begin
                o_result.red_first   = i_byte_one;
                o_result.green_first = i_byte_one;
                o_result.blue_first  = i_byte_one;
            end
            FMT_YUYV, FMT_UYVY: begin
                o_result.red_first    = i_lane_first.red;
                o_result.green_first  = i_lane_first.green;
                o_result.blue_first   = i_lane_first.blue;
                o_result.red_second   = i_lane_second.red;
                o_result.green_second = i_lane_second.green;
                o_result.blue_second  = i_lane_second.blue;
                o_result.alpha_second = ALPHA_OPAQUE;
                o_result.pixel_count  = COUNT_TWO;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

[hw/rtl/pixel_format_to_rgbx_converter_core.sv]
// Top level of the pixel format to RGBA converter: handshake, register port, lanes, output.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_stall    i_byte_zero .. i_byte_three
// output    o_valid / i_stall    o_red_first .. o_alpha_second, o_pixel_count
// config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// Two register stages: products in the lanes, then the output register.
// One item per cycle while i_stall is low; items pass stage one, then the output register.
// Throughput is set by the two YUV lanes, one full pixel each per cycle when not stalled.
// i_stall holds the output register; stage one keeps filling into a bubble,
// so o_stall rises only when both stages hold items.
// Synchronous active-low reset clears valids and source_format (RGB8).

module pixel_format_to_rgbx_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_zero,
    input  logic [7:0]  i_byte_one,
    input  logic [7:0]  i_byte_two,
    input  logic [7:0]  i_byte_three,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_first,
    output logic [7:0]  o_green_first,
    output logic [7:0]  o_blue_first,
    output logic [7:0]  o_alpha_first,
    output logic [7:0]  o_red_second,
    output logic [7:0]  o_green_second,
    output logic [7:0]  o_blue_second,
    output logic [7:0]  o_alpha_second,
    output logic [1:0]  o_pixel_count,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfc_pkg::*;

    // configuration
    logic [2:0] r_format;
    logic       w_cfg_wr;

    // pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_load;
    logic w_s1_load;
    logic w_in_acc;

    // stage one payload
    logic [2:0] r_s1_format;
    logic [7:0] r_s1_b0;
    logic [7:0] r_s1_b1;
    logic [7:0] r_s1_b2;
    logic [7:0] r_s1_b3;

    // lane inputs
    logic       w_is_uyvy;
    logic [7:0] w_y_first;
    logic [7:0] w_y_second;
    logic [7:0] w_cb;
    logic [7:0] w_cr;

    t_pixel  w_pix_first;
    t_pixel  w_pix_second;
    t_result w_result;
    t_result r_out;

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SOURCE_FORMAT);
    assign prdata   = (paddr[2] == REG_SOURCE_FORMAT) ? {29'd0, r_format} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGB8;
        end else if (w_cfg_wr) begin
            r_format <= pwdata[2:0];
        end
    end

    // ---------------- flow control ----------------
    // Output register loads when empty or drained; stage one moves with it.
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_stall    = !w_s1_load;
    assign w_in_acc   = i_valid && w_s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_format <= r_format;
            r_s1_b0     <= i_byte_zero;
            r_s1_b1     <= i_byte_one;
            r_s1_b2     <= i_byte_two;
            r_s1_b3     <= i_byte_three;
        end
    end

    // ---------------- YUV lanes ----------------
    // YUYV: Y1 U Y2 V; UYVY: U Y1 V Y2. Both lanes share the chroma pair.
    assign w_is_uyvy  = (r_format == FMT_UYVY);
    assign w_y_first  = w_is_uyvy ? i_byte_one   : i_byte_zero;
    assign w_y_second = w_is_uyvy ? i_byte_three : i_byte_two;
    assign w_cb       = w_is_uyvy ? i_byte_zero  : i_byte_one;
    assign w_cr       = w_is_uyvy ? i_byte_two   : i_byte_three;

    pfc_yuv_lane u_lane_first (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_luma  (w_y_first),
        .i_cb    (w_cb),
        .i_cr    (w_cr),
        .o_pixel (w_pix_first)
    );

    pfc_yuv_lane u_lane_second (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_luma  (w_y_second),
        .i_cb    (w_cb),
        .i_cr    (w_cr),
        .o_pixel (w_pix_second)
    );

    // ---------------- merge and output ----------------
    pfc_merge u_merge (
        .i_format      (r_s1_format),
        .i_byte_zero   (r_s1_b0),
        .i_byte_one    (r_s1_b1),
        .i_byte_two    (r_s1_b2),
        .i_byte_three  (r_s1_b3),
        .i_lane_first  (w_pix_first),
        .i_lane_second (w_pix_second),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_first    = r_out.red_first;
    assign o_green_first  = r_out.green_first;
    assign o_blue_first   = r_out.blue_first;
    assign o_alpha_first  = r_out.alpha_first;
    assign o_red_second   = r_out.red_second;
    assign o_green_second = r_out.green_second;
    assign o_blue_second  = r_out.blue_second;
    assign o_alpha_second = r_out.alpha_second;
    assign o_pixel_count  = r_out.pixel_count;

`ifndef NO_ASSERTIONS
    // stall toward the source only when both stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled while a stage is free");

    // an item in stage one with an empty output register moves on next cycle
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("stage one item did not advance");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_count == COUNT_ONE || o_pixel_count == COUNT_TWO))
        else $error("pixel count out of range");

    // single-pixel formats leave the second pixel zero
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_count == COUNT_ONE) |->
            (o_red_second == 8'd0 && o_green_second == 8'd0 &&
             o_blue_second == 8'd0 && o_alpha_second == 8'd0))
        else $error("second pixel not cleared for single-pixel format");

    a_second_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_count == COUNT_TWO) |->
            (o_alpha_second == ALPHA_OPAQUE && o_alpha_first == ALPHA_OPAQUE))
        else $error("YUV pixel alpha not opaque");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the pixel format to RGBA converter core.
`timescale 1ns / 1ps

module tb;
    import pfc_pkg::*;

    // Byte addresses on the register port: one 32-bit word per register.
    localparam logic [2:0] ADDR_SOURCE_FORMAT = {REG_SOURCE_FORMAT, 2'b00};
    localparam logic [2:0] ADDR_SPARE         = {~REG_SOURCE_FORMAT, 2'b00};

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 70;
    localparam int REPORT_LIMIT = 10;

    // Receiver stall patterns, chosen by the receiver process itself.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_zero = '0;
    logic [7:0]  i_byte_one = '0;
    logic [7:0]  i_byte_two = '0;
    logic [7:0]  i_byte_three = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red_first;
    logic [7:0]  o_green_first;
    logic [7:0]  o_blue_first;
    logic [7:0]  o_alpha_first;
    logic [7:0]  o_red_second;
    logic [7:0]  o_green_second;
    logic [7:0]  o_blue_second;
    logic [7:0]  o_alpha_second;
    logic [1:0]  o_pixel_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_format_to_rgbx_converter_core uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the source_format register, updated on every source_format write we issue.
    logic [2:0] format_shadow = FMT_RGB8;
    // Pixels predicted for each accepted group, oldest first.
    t_result    pending_pixels[$];

    int groups_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int reg_reads = 0;

    // Sender burst shaping: burst_left items go out back to back, then a gap.
    int  burst_left = 0;
    bit  gapless = 1'b0;

    // Receiver state. hold_cycles is requested by a test and counted down
    // in the receiver process.
    int          hold_cycles = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          periodic_phase = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] sat_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'hFF;
        return v[7:0];
    endfunction

    // Integer BT.601, 8-bit fraction, rounded; >>> on int floors.
    function automatic t_pixel bt601_pixel(input logic [7:0] luma, input logic [7:0] cb,
                                           input logic [7:0] cr);
        int     c;
        int     d;
        int     e;
        t_pixel p;
        c = int'(luma) - 16;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        p.red   = sat_byte((298 * c + 409 * e + 128) >>> 8);
        p.green = sat_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
        p.blue  = sat_byte((298 * c + 516 * d + 128) >>> 8);
        return p;
    endfunction

    function automatic t_result convert_group(input logic [2:0] fmt, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
        t_result r;
        t_pixel  p0;
        t_pixel  p1;
        r = '0;
        r.pixel_count = COUNT_ONE;
        r.alpha_first = ALPHA_OPAQUE;
        case (fmt)
            FMT_RGB8: begin
                {r.red_first, r.green_first, r.blue_first} = {b0, b1, b2};
            end
            FMT_BGR8: begin
                {r.red_first, r.green_first, r.blue_first} = {b2, b1, b0};
            end
            FMT_RGBA8: begin
                {r.red_first, r.green_first, r.blue_first, r.alpha_first} = {b0, b1, b2, b3};
            end
            FMT_BGRA8: begin
                {r.red_first, r.green_first, r.blue_first, r.alpha_first} = {b2, b1, b0, b3};
            end
            FMT_Y8: begin
                {r.red_first, r.green_first, r.blue_first} = {b0, b0, b0};
            end
            FMT_Y16: begin
                // high byte of the little-endian word
                {r.red_first, r.green_first, r.blue_first} = {b1, b1, b1};
            end
            FMT_YUYV: begin
                p0 = bt601_pixel(b0, b1, b3);
                p1 = bt601_pixel(b2, b1, b3);
            end
            default: begin
                // UYVY
                p0 = bt601_pixel(b1, b0, b2);
                p1 = bt601_pixel(b3, b0, b2);
            end
        endcase
        if (fmt == FMT_YUYV || fmt == FMT_UYVY) begin
            {r.red_first, r.green_first, r.blue_first} = p0;
            {r.red_second, r.green_second, r.blue_second} = p1;
            r.alpha_second = ALPHA_OPAQUE;
            r.pixel_count = COUNT_TWO;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // the register takes the value at this edge
        if (addr == ADDR_SOURCE_FORMAT) format_shadow = data[2:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic [2:0] addr);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        reg_reads++;
        if (got !== {29'd0, format_shadow}) begin
            if (mismatches < REPORT_LIMIT)
                $display("[%0t] source_format readback: expected %0h, got %0h",
                         $realtime, {29'd0, format_shadow}, got);
            mismatches++;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_group(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        int gap;
        i_valid <= 1'b1;
        i_byte_zero <= b0;
        i_byte_one <= b1;
        i_byte_two <= b2;
        i_byte_three <= b3;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(convert_group(format_shadow, b0, b1, b2, b3));
        groups_sent++;
        if (gapless) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly random bytes, with the arithmetic corners mixed in.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h10;
            3: return 8'h80;
            4: return 8'hEB;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    // Pause the sender until the pipeline has delivered everything.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern it picks itself, plus requested holds
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            periodic_phase = (periodic_phase + 1) % 5;
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_stall <= (periodic_phase < 2);
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic bit field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got === want) return 1'b0;
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] result %0d %s: expected %0h, got %0h",
                     $realtime, results_seen, name, want, got);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        bit      bad;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("[%0t] result with no group outstanding", $realtime);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                bad = 1'b0;
                bad |= field_bad("red_first", want.red_first, o_red_first);
                bad |= field_bad("green_first", want.green_first, o_green_first);
                bad |= field_bad("blue_first", want.blue_first, o_blue_first);
                bad |= field_bad("alpha_first", want.alpha_first, o_alpha_first);
                bad |= field_bad("red_second", want.red_second, o_red_second);
                bad |= field_bad("green_second", want.green_second, o_green_second);
                bad |= field_bad("blue_second", want.blue_second, o_blue_second);
                bad |= field_bad("alpha_second", want.alpha_second, o_alpha_second);
                bad |= field_bad("pixel_count", {6'd0, want.pixel_count},
                                 {6'd0, o_pixel_count});
                if (bad) mismatches++;
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves the block in RGB8.
    task automatic test_reset_default;
        reg_check(ADDR_SOURCE_FORMAT);
        send_group(8'h12, 8'h34, 8'h56, 8'h78);
        send_group(8'hFF, 8'h00, 8'hFF, 8'h00);
        drain();
    endtask

    // Only the low three bits are kept; a write to the spare word is ignored.
    task automatic test_register_port;
        reg_write(ADDR_SOURCE_FORMAT, 32'hFFFF_FFF9);
        reg_check(ADDR_SOURCE_FORMAT);
        reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
        reg_check(ADDR_SOURCE_FORMAT);
        send_group(8'h01, 8'h02, 8'h03, 8'h04);
        send_group(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        drain();
    endtask

    // Every format with all-zero, all-one and one telling pattern.
    task automatic test_format_corners;
        logic [2:0] fmt;
        for (int f = 0; f < 8; f++) begin
            fmt = f[2:0];
            reg_write(ADDR_SOURCE_FORMAT, {29'd0, fmt});
            send_group(8'h00, 8'h00, 8'h00, 8'h00);
            send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            if (fmt == FMT_YUYV)
                send_group(8'h10, 8'h80, 8'hEB, 8'h80);   // black then full white
            else if (fmt == FMT_UYVY)
                send_group(8'h00, 8'hEB, 8'hFF, 8'h10);   // strong chroma, clamps both ways
            else
                send_group(8'h55, 8'hAA, 8'h0F, 8'hF0);   // unused bytes must not leak
            drain();
        end
    endtask

    // Random streams, one phase per format setting with junk in the upper bits
    // of each write; both end codes come up more than once.
    task automatic test_random_streams;
        logic [2:0] phase_formats[10];
        phase_formats = '{FMT_UYVY, FMT_RGB8, FMT_YUYV, FMT_BGR8, FMT_RGBA8,
                          FMT_BGRA8, FMT_Y8, FMT_Y16, FMT_UYVY, FMT_RGB8};
        foreach (phase_formats[p]) begin
            reg_write(ADDR_SOURCE_FORMAT,
                      ($urandom() & 32'hFFFF_FFF8) | {29'd0, phase_formats[p]});
            if ($urandom_range(0, 1)) reg_check(ADDR_SOURCE_FORMAT);
            // some phases run the sender flat out
            gapless = ($urandom_range(0, 3) == 0);
            send_random(PHASE_ITEMS - 10 + $urandom_range(0, 20));
            gapless = 1'b0;
            drain();
        end
    endtask

    // Long receiver hold while the sender keeps offering items: the two
    // stages fill and o_stall must hold the input until the hold ends.
    task automatic test_backpressure;
        reg_write(ADDR_SOURCE_FORMAT, {29'd0, FMT_YUYV});
        gapless = 1'b1;
        hold_cycles = 80;
        send_random(40);
        gapless = 1'b0;
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_default();
        test_register_port();
        test_format_corners();
        test_random_streams();
        test_backpressure();

        drain();
        repeat (8) @(posedge i_clk);

        $display("Converted %0d pixel groups over all eight source formats, %0d results checked,",
                 groups_sent, results_seen);
        $display("%0d register readbacks, %0d mismatches.", reg_reads, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
